### hdl/ookt_pkg.sv
package ookt_pkg;

  // Code store size; longer lengths saturate to this.
  localparam int CODE_BITS = 32;

  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int UNIT_W = 16;
  localparam int REP_W  = 8;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 16;

  localparam logic [LEN_W-1:0] CODE_BITS_LEN = LEN_W'(CODE_BITS);

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_UNIT_TICKS   = 8'd0;
  localparam logic [IDX_W-1:0] REG_REPEAT_COUNT = 8'd1;
  localparam logic [IDX_W-1:0] REG_SYNC_FIRST   = 8'd2;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST   = 16'd350;
  localparam logic [REP_W-1:0]  REPEAT_COUNT_RST = 8'd10;

  // Pulse unit counts
  localparam logic [CNT_W-1:0] UNITS_SHORT    = 5'd1;
  localparam logic [CNT_W-1:0] UNITS_LONG     = 5'd3;
  localparam logic [CNT_W-1:0] UNITS_SYNC_LOW = 5'd31;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_ticks;
    logic [REP_W-1:0]  repeat_count;
    logic              sync_first;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic done_res;
  } result_t;

endpackage

### hdl/ookt_if.sv
interface ookt_in_if;
  import ookt_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] code_word;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, output func, output code_word, output code_length,
                  input ready);
  modport sink   (input valid, input func, input code_word, input code_length,
                  output ready);
endinterface

interface ookt_out_if;
  logic valid;
  logic ready;
  logic tx_level;
  logic busy_res;
  logic done_res;

  modport source (output valid, output tx_level, output busy_res, output done_res,
                  input ready);
  modport sink   (input valid, input tx_level, input busy_res, input done_res,
                  output ready);
endinterface

### hdl/ookt_cfg_regs.sv
module ookt_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ookt_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ookt_pkg::CFG_W-1:0] cfg_data_i,
  output ookt_pkg::cfg_t             cfg_o
);
  import ookt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UNIT_TICKS:   cfg_d.unit_ticks   = cfg_data_i;
        REG_REPEAT_COUNT: cfg_d.repeat_count = cfg_data_i[REP_W-1:0];
        REG_SYNC_FIRST:   cfg_d.sync_first   = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_ticks   <= UNIT_TICKS_RST;
      cfg_q.repeat_count <= REPEAT_COUNT_RST;
      cfg_q.sync_first   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/ookt_in_stage.sv
module ookt_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ookt_pkg::item_t in_item_i,
  output logic            stg_valid_o,
  output ookt_pkg::item_t stg_item_o,
  input  logic            stg_adv_i
);
  import ookt_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Take a new word whenever the held one leaves this cycle.
  assign in_ready_o = !valid_q || stg_adv_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign stg_valid_o = valid_q;
  assign stg_item_o  = item_q;

endmodule

### hdl/ookt_core.sv
module ookt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ookt_pkg::cfg_t    cfg_i,
  input  logic              stg_valid_i,
  input  ookt_pkg::item_t   stg_item_i,
  output logic              stg_adv_o,
  output logic              res_valid_o,
  output ookt_pkg::result_t res_o,
  input  logic              res_ready_i
);
  import ookt_pkg::*;

  logic [WORD_W-1:0] code_q, code_d;
  logic [LEN_W-1:0]  bits_q, bits_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [REP_W-1:0]  reps_q, reps_d;
  logic              sync_q, sync_d;
  logic              low_q, low_d;
  logic [CNT_W-1:0]  units_q, units_d;
  logic [UNIT_W-1:0] tick_q, tick_d;
  logic              active_q, active_d;
  logic              lead_q, lead_d;

  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  logic [LEN_W-1:0]  len_sat;
  logic              start_sync;
  logic              tick_wrap;
  logic [CNT_W-1:0]  units_dec;
  logic [REP_W-1:0]  reps_dec;
  logic [LEN_W-1:0]  bits_dec;

  // Bit n-1 of the code, zero for n == 0.
  function automatic logic bit_at(input logic [WORD_W-1:0] code, input logic [LEN_W-1:0] n);
    logic [CNT_W-1:0] idx;
    idx = CNT_W'(n - LEN_W'(1));
    if (n == '0) begin
      return 1'b0;
    end
    return code[idx];
  endfunction

  function automatic logic [CNT_W-1:0] high_units(input logic b);
    return b ? UNITS_LONG : UNITS_SHORT;
  endfunction

  assign stg_adv_o = stg_valid_i && (!res_valid_q || res_ready_i);

  assign len_sat    = (stg_item_i.code_length > CODE_BITS_LEN) ? CODE_BITS_LEN
                                                               : stg_item_i.code_length;
  assign start_sync = cfg_i.sync_first || (len_sat == '0);
  assign tick_wrap  = ({1'b0, tick_q} + 17'd1) >= {1'b0, cfg_i.unit_ticks};
  assign units_dec  = (units_q != '0) ? units_q - CNT_W'(1) : '0;
  assign reps_dec   = (reps_q != '0) ? reps_q - REP_W'(1) : '0;
  assign bits_dec   = (bits_q != '0) ? bits_q - LEN_W'(1) : '0;

  always_comb begin
    code_d   = code_q;
    bits_d   = bits_q;
    len_d    = len_q;
    reps_d   = reps_q;
    sync_d   = sync_q;
    low_d    = low_q;
    units_d  = units_q;
    tick_d   = tick_q;
    active_d = active_q;
    lead_d   = lead_q;
    res_d    = '0;

    if (stg_item_i.func) begin
      res_d.busy_res = 1'b1;
      if (active_q) begin
        res_d.tx_level = !low_q;
      end else begin
        code_d   = stg_item_i.code_word;
        len_d    = len_sat;
        bits_d   = len_sat;
        lead_d   = cfg_i.sync_first;
        reps_d   = (cfg_i.sync_first || cfg_i.repeat_count == '0) ? REP_W'(1)
                                                                   : cfg_i.repeat_count;
        active_d = 1'b1;
        sync_d   = start_sync;
        low_d    = 1'b0;
        tick_d   = '0;
        units_d  = start_sync ? UNITS_SHORT : high_units(bit_at(stg_item_i.code_word, len_sat));
      end
    end else if (active_q) begin
      res_d.tx_level = !low_q;
      res_d.busy_res = 1'b1;
      if (tick_wrap) begin
        tick_d  = '0;
        units_d = units_dec;
        if (units_dec == '0) begin
          if (!low_q) begin
            low_d   = 1'b1;
            units_d = sync_q ? UNITS_SYNC_LOW
                             : (bit_at(code_q, bits_q) ? UNITS_SHORT : UNITS_LONG);
          end else begin
            // End of symbol: pick the next one or finish
            low_d = 1'b0;
            if (sync_q) begin
              if (lead_q) begin
                if (bits_q != '0) begin
                  sync_d  = 1'b0;
                  units_d = high_units(bit_at(code_q, bits_q));
                end else begin
                  active_d       = 1'b0;
                  res_d.done_res = 1'b1;
                end
              end else begin
                reps_d = reps_dec;
                if (reps_dec == '0) begin
                  active_d       = 1'b0;
                  res_d.done_res = 1'b1;
                end else begin
                  bits_d  = len_q;
                  sync_d  = (len_q == '0);
                  units_d = (len_q == '0) ? UNITS_SHORT : high_units(bit_at(code_q, len_q));
                end
              end
            end else begin
              bits_d = bits_dec;
              if (bits_dec != '0) begin
                units_d = high_units(bit_at(code_q, bits_dec));
              end else if (lead_q) begin
                active_d       = 1'b0;
                res_d.done_res = 1'b1;
              end else begin
                sync_d  = 1'b1;
                units_d = UNITS_SHORT;
              end
            end
          end
        end
      end else begin
        tick_d = tick_q + UNIT_W'(1);
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (stg_adv_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= '0;
      bits_q      <= '0;
      len_q       <= '0;
      reps_q      <= '0;
      sync_q      <= 1'b0;
      low_q       <= 1'b0;
      units_q     <= '0;
      tick_q      <= '0;
      active_q    <= 1'b0;
      lead_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (stg_adv_o) begin
        code_q   <= code_d;
        bits_q   <= bits_d;
        len_q    <= len_d;
        reps_q   <= reps_d;
        sync_q   <= sync_d;
        low_q    <= low_d;
        units_q  <= units_d;
        tick_q   <= tick_d;
        active_q <= active_d;
        lead_q   <= lead_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/ook_pulse_width_code_transmitter.sv
// Pulse-width OOK code transmitter.
// Input channel in_i carries one word per item: func 1 starts (if idle) a
// transmission of code_word (code_length bits, MSB first, above 32 saturate),
// func 0 is one timer tick. Every accepted word yields exactly one word on
// out_o with the tick's keying level, busy_res and done_res (set on last tick).
// Symbols: one = 3 units high, 1 low; zero = 1 high, 3 low; sync = 1 high,
// 31 low; a unit is unit_ticks ticks. Repeat mode sends code plus sync
// repeat_count times; sync-first mode sends a leading sync, then the code once.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 unit_ticks, 1 repeat_count, 2 sync_first); write only while idle.
// Path: an accepted word waits in the input register and is processed into the
// result register once that register is free or its word is being taken.
// Throughput: one word per cycle while out_o is ready; the symbol state update
// is a single pass of logic between the input register and the result register.
// Reset: async active low; the block comes up idle with unit_ticks 350,
// repeat_count 10, sync_first 0 and no result pending.
// Stall: while out_o is not ready, the result holds, the input register fills
// and in_i.ready then drops; no word is lost or repeated.
module ook_pulse_width_code_transmitter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ookt_in_if.sink                    in_i,
  ookt_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [ookt_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ookt_pkg::CFG_W-1:0] cfg_data_i
);
  import ookt_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   stg_item;
  logic    stg_valid;
  logic    stg_adv;
  logic    in_ready;
  logic    res_valid;
  result_t res;

  assign in_item.func        = in_i.func;
  assign in_item.code_word   = in_i.code_word;
  assign in_item.code_length = in_i.code_length;
  assign in_i.ready          = in_ready;

  ookt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ookt_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .stg_valid_o (stg_valid),
    .stg_item_o  (stg_item),
    .stg_adv_i   (stg_adv)
  );

  ookt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stg_valid_i (stg_valid),
    .stg_item_i  (stg_item),
    .stg_adv_o   (stg_adv),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (out_o.ready)
  );

  assign out_o.valid    = res_valid;
  assign out_o.tx_level = res.tx_level;
  assign out_o.busy_res = res.busy_res;
  assign out_o.done_res = res.done_res;

endmodule

### hdl/ookt_checker.sv
module ookt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic tx_level_i,
  input logic busy_res_i,
  input logic done_res_i
);

  // A finished transmission is still busy on its last tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> busy_res_i)
    else $error("done word without busy");

  // The last tick of a transmission falls in a low half.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_res_i |-> !tx_level_i)
    else $error("done word with carrier on");

  // Carrier stays off while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> !tx_level_i)
    else $error("carrier on while idle");

  // Hold a stalled result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_level_i)
      && $stable(busy_res_i) && $stable(done_res_i))
    else $error("stalled result word changed");

  // An accepted word passes the input register before a result word is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 out_valid_i)
    else $error("accepted word gave no result");

endmodule

bind ook_pulse_width_code_transmitter ookt_checker u_ookt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .tx_level_i  (out_o.tx_level),
  .busy_res_i  (out_o.busy_res),
  .done_res_i  (out_o.done_res)
);
